/* sv/lbs_pkg.sv */
// ----------------------------------------------------------------------------
// lbs_pkg
// shared constants and types of the vertex skinning block
// ----------------------------------------------------------------------------
`default_nettype none

package lbs_pkg;

    localparam int BONES          = 64;
    localparam int MAX_INFLUENCES = 10;
    localparam int ELEMS          = 12;
    localparam int PAL_DEPTH      = BONES * ELEMS;
    localparam int PAL_AW         = $clog2(PAL_DEPTH);
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_AW        = $clog2(FIFO_DEPTH);
    localparam int CNT_W          = 4;
    localparam int ACC_W          = 40;
    localparam int SUM_W          = 58;
    localparam int PROD_W         = 57;
    localparam int IN_DATA_W      = 160;
    localparam int OUT_DATA_W     = 96;
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_ACC,
        OP_SKIP
    } t_op;

    typedef enum logic [1:0] {
        TAG_INF,
        TAG_HI,
        TAG_LO
    } t_tag;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INF,
        ST_DRAIN,
        ST_ROW,
        ST_ROWWAIT,
        ST_ROWSAT,
        ST_FIN
    } t_state;

    typedef struct packed {
        t_op                op;
        logic [PAL_AW-1:0]  addr;
        logic signed [31:0] value;
        logic [16:0]        weight;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               last;
    } t_cmd;

endpackage

`default_nettype wire

/* sv/linear_blend_skinning.sv */
// ----------------------------------------------------------------------------
// linear_blend_skinning
// fixed point vertex skinning with a 64 bone palette
// ----------------------------------------------------------------------------
// the slave stream carries load and influence items; tuser selects the kind
// (0 writes one palette element, 1 adds one influence) and tlast marks the
// final influence of a vertex, whose transfer also carries the position.
// the master stream carries one skinned position per vertex.
// a front stage classifies each transfer and queues a command (four deep);
// a back stage executes commands through one shared multiplier.
// a palette write is stored as it leaves the queue; an influence takes the
// command and then reads the palette once per matrix element.
// a vertex ends with the pipeline drain, then per row six multiplies, a wait
// and a saturation, and last the result register load, which raises tvalid.
// reset empties the queue, clears the accumulator and the influence count
// and drops any pending result; the palette keeps no reset value.
// a stalled receiver holds the result register; the back stage waits, the
// queue fills and then tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_blend_skinning (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // bone_index, element_index, matrix_value, blend_weight, pos_x, pos_y, pos_z
    input  wire logic [lbs_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // action
    input  wire logic                              i_s_axis_tuser,
    input  wire logic                              i_s_axis_tlast,
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // out_x, out_y, out_z
    output logic [lbs_pkg::OUT_DATA_W-1:0]         o_m_axis_tdata
);

    logic          push;
    logic          pop;
    logic          full;
    logic          empty;
    lbs_pkg::t_cmd cmd_in;
    lbs_pkg::t_cmd cmd_out;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;

    lbs_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_s_axis_tvalid),
        .o_ready         (o_s_axis_tready),
        .i_action        (i_s_axis_tuser),
        .i_bone_index    (i_s_axis_tdata[5:0]),
        .i_element_index (i_s_axis_tdata[9:6]),
        .i_matrix_value  (i_s_axis_tdata[41:10]),
        .i_blend_weight  (i_s_axis_tdata[58:42]),
        .i_pos_x         (i_s_axis_tdata[90:59]),
        .i_pos_y         (i_s_axis_tdata[122:91]),
        .i_pos_z         (i_s_axis_tdata[154:123]),
        .i_last          (i_s_axis_tlast),
        .i_full          (full),
        .o_push          (push),
        .o_cmd           (cmd_in)
    );

    lbs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_cmd   (cmd_out)
    );

    lbs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_cmd   (cmd_out),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_x     (out_x),
        .o_y     (out_y),
        .o_z     (out_z)
    );

    assign o_m_axis_tdata = {out_z, out_y, out_x};

endmodule

`default_nettype wire

/* sv/lbs_front.sv */
// ----------------------------------------------------------------------------
// lbs_front
// accepts input transfers, tracks the influence count and turns each kept item
// into a command for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module lbs_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic                            i_action,
    input  wire logic [5:0]                      i_bone_index,
    input  wire logic [3:0]                      i_element_index,
    input  wire logic signed [31:0]              i_matrix_value,
    input  wire logic [16:0]                     i_blend_weight,
    input  wire logic signed [31:0]              i_pos_x,
    input  wire logic signed [31:0]              i_pos_y,
    input  wire logic signed [31:0]              i_pos_z,
    input  wire logic                            i_last,
    input  wire logic                            i_full,
    output logic                                 o_push,
    output lbs_pkg::t_cmd                        o_cmd
);

    logic [lbs_pkg::CNT_W-1:0] r_count;
    logic [lbs_pkg::CNT_W-1:0] n_count;
    logic                      accept;
    logic                      bone_ok;
    logic                      elem_ok;
    logic                      room;
    logic                      keep;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign bone_ok = 11'(i_bone_index) < 11'(lbs_pkg::BONES);
    assign elem_ok = 5'(i_element_index) < 5'(lbs_pkg::ELEMS);
    assign room    = 5'(r_count) < 5'(lbs_pkg::MAX_INFLUENCES);

    always_comb begin
        o_cmd.addr   = lbs_pkg::PAL_AW'(i_bone_index) * lbs_pkg::PAL_AW'(lbs_pkg::ELEMS);
        o_cmd.value  = i_matrix_value;
        o_cmd.weight = (i_blend_weight > lbs_pkg::ONE_Q16) ? lbs_pkg::ONE_Q16 : i_blend_weight;
        o_cmd.pos_x  = i_pos_x;
        o_cmd.pos_y  = i_pos_y;
        o_cmd.pos_z  = i_pos_z;
        o_cmd.last   = i_last;
        n_count      = r_count;
        if (!i_action) begin
            o_cmd.op   = lbs_pkg::OP_WRITE;
            o_cmd.addr = o_cmd.addr + lbs_pkg::PAL_AW'(i_element_index);
            keep       = bone_ok && elem_ok;
        end else begin
            o_cmd.op = (room && bone_ok) ? lbs_pkg::OP_ACC : lbs_pkg::OP_SKIP;
            keep     = (room && bone_ok) || i_last;
            if (room) begin
                n_count = r_count + 1'b1;
            end
            if (i_last) begin
                n_count = '0;
            end
        end
    end

    assign o_push = accept && keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (accept) begin
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

/* sv/lbs_fifo.sv */
// ----------------------------------------------------------------------------
// lbs_fifo
// short command queue between the front and the back end
// ----------------------------------------------------------------------------
`default_nettype none

module lbs_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire lbs_pkg::t_cmd i_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_empty,
    output lbs_pkg::t_cmd      o_cmd
);

    lbs_pkg::t_cmd              r_mem [lbs_pkg::FIFO_DEPTH];
    logic [lbs_pkg::FIFO_AW-1:0] r_wr;
    logic [lbs_pkg::FIFO_AW-1:0] r_rd;
    logic [lbs_pkg::FIFO_AW:0]   r_cnt;

    assign o_full  = r_cnt == (lbs_pkg::FIFO_AW+1)'(lbs_pkg::FIFO_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (lbs_pkg::FIFO_AW+1)'(i_push) - (lbs_pkg::FIFO_AW+1)'(i_pop);
        end
    end

endmodule

`default_nettype wire

/* sv/lbs_back.sv */
// ----------------------------------------------------------------------------
// lbs_back
// palette memory, blend accumulator and the shared multiplier sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module lbs_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_empty,
    input  wire lbs_pkg::t_cmd i_cmd,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic signed [31:0] o_x,
    output logic signed [31:0] o_y,
    output logic signed [31:0] o_z
);

    localparam logic signed [lbs_pkg::SUM_W-1:0] SAT_MAX = lbs_pkg::SUM_W'(64'sd2147483647);
    localparam logic signed [lbs_pkg::SUM_W-1:0] SAT_MIN = lbs_pkg::SUM_W'(-64'sd2147483648);

    logic signed [31:0]              r_pal [lbs_pkg::PAL_DEPTH];
    logic signed [lbs_pkg::ACC_W-1:0] r_acc [lbs_pkg::ELEMS];

    lbs_pkg::t_state r_state;
    lbs_pkg::t_state n_state;
    lbs_pkg::t_cmd   r_cmd;
    logic [3:0]      r_k;
    logic [1:0]      r_row;

    logic                              r_rv;
    logic [3:0]                        r_ridx;
    logic signed [31:0]                r_rd;
    logic                              r_pv;
    lbs_pkg::t_tag                     r_ptag;
    logic [3:0]                        r_pidx;
    logic signed [lbs_pkg::PROD_W-1:0] r_prod;
    logic signed [lbs_pkg::SUM_W-1:0]  r_sum;
    logic signed [31:0]                r_res [3];
    logic signed [31:0]                r_ox;
    logic signed [31:0]                r_oy;
    logic signed [31:0]                r_oz;
    logic                              r_ovalid;

    logic                             mem_we;
    logic                             fin_go;
    logic [3:0]                       acc_ridx;
    logic signed [lbs_pkg::ACC_W-1:0] acc_rd;
    logic signed [32:0]               mul_a;
    logic signed [31:0]               mul_b;
    logic signed [31:0]               pos_c;
    logic signed [31:0]               sat_val;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lbs_pkg::ST_IDLE: begin
                if (!i_empty) begin
                    unique case (i_cmd.op)
                        lbs_pkg::OP_ACC:  n_state = lbs_pkg::ST_INF;
                        lbs_pkg::OP_SKIP: n_state = lbs_pkg::ST_DRAIN;
                        default:          n_state = lbs_pkg::ST_IDLE;
                    endcase
                end
            end
            lbs_pkg::ST_INF: begin
                if (r_k == 4'(lbs_pkg::ELEMS - 1)) begin
                    n_state = r_cmd.last ? lbs_pkg::ST_DRAIN : lbs_pkg::ST_IDLE;
                end
            end
            lbs_pkg::ST_DRAIN: begin
                if (!r_rv && !r_pv) begin
                    n_state = lbs_pkg::ST_ROW;
                end
            end
            lbs_pkg::ST_ROW: begin
                if (r_k == 4'd5) begin
                    n_state = lbs_pkg::ST_ROWWAIT;
                end
            end
            lbs_pkg::ST_ROWWAIT: n_state = lbs_pkg::ST_ROWSAT;
            lbs_pkg::ST_ROWSAT:  n_state = (r_row == 2'd2) ? lbs_pkg::ST_FIN : lbs_pkg::ST_ROW;
            lbs_pkg::ST_FIN: begin
                if (fin_go) begin
                    n_state = lbs_pkg::ST_IDLE;
                end
            end
            default: n_state = lbs_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_pop    = (r_state == lbs_pkg::ST_IDLE) && !i_empty;
        mem_we   = o_pop && (i_cmd.op == lbs_pkg::OP_WRITE);
        fin_go   = (r_state == lbs_pkg::ST_FIN) && (!r_ovalid || i_ready);
        unique case (r_state)
            lbs_pkg::ST_DRAIN:  acc_ridx = r_pv ? r_pidx : 4'd3;
            lbs_pkg::ST_ROW:    acc_ridx = {r_row, r_k[2:1]};
            lbs_pkg::ST_ROWSAT: acc_ridx = (r_row == 2'd2) ? 4'd3 : {r_row + 2'd1, 2'd3};
            default:            acc_ridx = r_pidx;
        endcase
    end

    assign acc_rd = r_acc[acc_ridx];

    always_comb begin
        unique case (r_k[2:1])
            2'd0:    pos_c = r_cmd.pos_x;
            2'd1:    pos_c = r_cmd.pos_y;
            default: pos_c = r_cmd.pos_z;
        endcase
        if (r_rv) begin
            mul_a = 33'(r_rd);
            mul_b = 32'($signed({15'd0, r_cmd.weight}));
        end else begin
            mul_a = r_k[0] ? $signed({17'd0, acc_rd[15:0]}) : 33'($signed(acc_rd[39:16]));
            mul_b = pos_c;
        end
    end

    always_comb begin
        if (r_sum > SAT_MAX) begin
            sat_val = 32'sh7fffffff;
        end else if (r_sum < SAT_MIN) begin
            sat_val = 32'sh80000000;
        end else begin
            sat_val = r_sum[31:0];
        end
    end

    // palette memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_pal[i_cmd.addr] <= i_cmd.value;
        end
        r_rd <= r_pal[r_cmd.addr + lbs_pkg::PAL_AW'(r_k)];
    end

    // sequencer and multiply pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lbs_pkg::ST_IDLE;
            r_k      <= '0;
            r_row    <= '0;
            r_rv     <= 1'b0;
            r_pv     <= 1'b0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < lbs_pkg::ELEMS; i++) begin
                r_acc[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_cmd <= i_cmd;
            end

            if (r_state == lbs_pkg::ST_INF || r_state == lbs_pkg::ST_ROW) begin
                r_k <= (n_state == r_state) ? r_k + 1'b1 : '0;
            end else begin
                r_k <= '0;
            end

            r_rv   <= r_state == lbs_pkg::ST_INF;
            r_ridx <= r_k;
            r_pv   <= r_rv || (r_state == lbs_pkg::ST_ROW);
            r_pidx <= r_ridx;
            r_ptag <= r_rv ? lbs_pkg::TAG_INF : (r_k[0] ? lbs_pkg::TAG_LO : lbs_pkg::TAG_HI);
            r_prod <= lbs_pkg::PROD_W'(mul_a) * lbs_pkg::PROD_W'(mul_b);

            if (r_pv) begin
                unique case (r_ptag)
                    lbs_pkg::TAG_INF: r_acc[r_pidx] <= acc_rd + lbs_pkg::ACC_W'(r_prod >>> 16);
                    lbs_pkg::TAG_HI:  r_sum <= r_sum + lbs_pkg::SUM_W'(r_prod);
                    default:          r_sum <= r_sum + lbs_pkg::SUM_W'(r_prod >>> 16);
                endcase
            end else if (r_state == lbs_pkg::ST_DRAIN || r_state == lbs_pkg::ST_ROWSAT) begin
                r_sum <= lbs_pkg::SUM_W'(acc_rd);
            end

            if (r_state == lbs_pkg::ST_DRAIN) begin
                r_row <= '0;
            end else if (r_state == lbs_pkg::ST_ROWSAT) begin
                r_res[r_row] <= sat_val;
                r_row        <= r_row + 1'b1;
            end

            if (fin_go) begin
                r_ox     <= r_res[0];
                r_oy     <= r_res[1];
                r_oz     <= r_res[2];
                r_ovalid <= 1'b1;
                for (int i = 0; i < lbs_pkg::ELEMS; i++) begin
                    r_acc[i] <= '0;
                end
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_x     = r_ox;
    assign o_y     = r_oy;
    assign o_z     = r_oz;

endmodule

`default_nettype wire

/* sv/lbs_checker.sv */
// ----------------------------------------------------------------------------
// lbs_checker
// port level checks of the skinning block
// ----------------------------------------------------------------------------
`default_nettype none

module lbs_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          o_s_axis_tready,
    input wire logic                          o_m_axis_tvalid,
    input wire logic                          i_m_axis_tready,
    input wire logic [lbs_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);

    a_reset_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    a_reset_ready: assert property (@(posedge i_clk) !i_rst_n |=> o_s_axis_tready)
        else $error("queue not empty after reset");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

endmodule

bind linear_blend_skinning lbs_checker u_lbs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire

/* bench/linear_blend_skinning_tb.sv */
// ----------------------------------------------------------------------------
// linear_blend_skinning_tb
// self-checking bench for the fixed point vertex skinning block
// ----------------------------------------------------------------------------
// a directed table loads one bone and runs the weight, clamp and saturation
// corners, then random palette loads and vertices of 1 to 13 influences follow.
// every vertex result is checked against an independent model of the palette,
// the blend accumulator and the row products, with random gaps on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_blend_skinning_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  RANDOM_ITEMS = 1950;
    localparam int  CYCLE_LIMIT  = 1000000;
    localparam bit  ACT_WRITE    = 1'b0;
    localparam bit  ACT_INFLUENCE = 1'b1;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_pos;

    typedef struct {
        bit                 act;
        logic [5:0]         bone;
        logic [3:0]         el;
        logic signed [31:0] val;
        logic [16:0]        w;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        bit                 last;
        bit                 typed;
        t_pos               res;
    } t_row;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              s_valid = 1'b0;
    logic                              o_s_axis_tready;
    logic [lbs_pkg::IN_DATA_W-1:0]     s_data = '0;
    logic                              s_user = 1'b0;
    logic                              s_last = 1'b0;
    logic                              o_m_axis_tvalid;
    logic                              m_ready = 1'b0;
    logic [lbs_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata;

    linear_blend_skinning DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // model state
    logic signed [31:0] palette [lbs_pkg::PAL_DEPTH];
    bit                 written [lbs_pkg::PAL_DEPTH];
    longint             blend [lbs_pkg::ELEMS];
    int                 inf_count;

    t_pos   skinned_q [$];
    int     errors = 0;
    int     n_results = 0;
    int     n_items = 0;
    int     n_vertices = 0;
    int     n_writes = 0;
    longint cycles = 0;
    bit     idle_on = 1'b1;

    task automatic report(input string what, input logic signed [31:0] got,
                          input logic signed [31:0] want);
        errors++;
        $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want,
                 n_results);
    endtask

    function automatic logic signed [31:0] sat32(input logic signed [127:0] v);
        if (v > 128'sd2147483647)
            return 32'sh7fffffff;
        if (v < -128'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    task automatic skin_model(input t_row r, output bit emit, output t_pos res);
        longint             wc;
        logic signed [127:0] sum, a128, p128;
        logic signed [31:0] pos [3];
        logic signed [31:0] row_out [3];
        int                 base;
        emit = 1'b0;
        res = '{0, 0, 0};
        base = int'(r.bone) * lbs_pkg::ELEMS;
        if (r.act == ACT_WRITE) begin
            if (r.el < lbs_pkg::ELEMS) begin
                palette[base + r.el] = r.val;
                written[base + r.el] = 1'b1;
            end
            return;
        end
        wc = (r.w > lbs_pkg::ONE_Q16) ? longint'(lbs_pkg::ONE_Q16) : longint'(r.w);
        if (inf_count < lbs_pkg::MAX_INFLUENCES) begin
            for (int c = 0; c < lbs_pkg::ELEMS; c++)
                blend[c] += (longint'(palette[base + c]) * wc) >>> 16;
            inf_count++;
        end
        if (!r.last)
            return;
        pos[0] = r.px;
        pos[1] = r.py;
        pos[2] = r.pz;
        for (int rw = 0; rw < 3; rw++) begin
            sum = blend[rw*4 + 3];
            for (int c = 0; c < 3; c++) begin
                a128 = blend[rw*4 + c];
                p128 = pos[c];
                sum += (a128 * p128) >>> 16;
            end
            row_out[rw] = sat32(sum);
        end
        res = '{row_out[0], row_out[1], row_out[2]};
        foreach (blend[c]) blend[c] = 0;
        inf_count = 0;
        emit = 1'b1;
    endtask

    task automatic send(input t_row r);
        int   gap;
        bit   emit;
        t_pos res;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= r.act;
        s_last  <= r.last;
        s_data  <= {5'b0, r.pz, r.py, r.px, r.w, r.val, r.el, r.bone};
        do @(posedge i_clk); while (!o_s_axis_tready);
        skin_model(r, emit, res);
        if (emit) begin
            if (r.typed) res = r.res;
            skinned_q.insert(skinned_q.size(), res);
            n_vertices++;
        end
        if (r.act == ACT_WRITE) n_writes++;
        n_items++;
        if ($urandom_range(0, 60) == 0) idle_on = ~idle_on;
    endtask

    // result side
    int stall = 0;
    always @(posedge i_clk) begin
        t_pos want;
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && m_ready) begin
                if (skinned_q.size() == 0) begin
                    errors++;
                    $display("unexpected result transfer");
                end else begin
                    want = skinned_q.pop_front();
                    if ($signed(o_m_axis_tdata[31:0]) !== want.x)
                        report("out_x", o_m_axis_tdata[31:0], want.x);
                    if ($signed(o_m_axis_tdata[63:32]) !== want.y)
                        report("out_y", o_m_axis_tdata[63:32], want.y);
                    if ($signed(o_m_axis_tdata[95:64]) !== want.z)
                        report("out_z", o_m_axis_tdata[95:64], want.z);
                end
                n_results++;
                stall = idle_on ? $urandom_range(0, 7) : 0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall = stall - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("linear_blend_skinning_tb failed");
            $finish;
        end
    end

    function automatic t_row load_row(input logic [5:0] bone, input logic [3:0] el,
                                      input logic signed [31:0] val);
        t_row r;
        r = '{ACT_WRITE, bone, el, val, 17'($urandom), 32'($urandom), 32'($urandom),
              32'($urandom), 1'($urandom), 1'b0, '{0, 0, 0}};
        return r;
    endfunction

    function automatic t_row inf_row(input logic [5:0] bone, input logic [16:0] w,
                                     input bit last, input logic signed [31:0] px,
                                     input logic signed [31:0] py,
                                     input logic signed [31:0] pz);
        t_row r;
        r = '{ACT_INFLUENCE, bone, 4'($urandom), 32'($urandom), w, px, py, pz, last,
              1'b0, '{0, 0, 0}};
        return r;
    endfunction

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 3))
            0: return 32'($urandom);
            1: return $signed(32'($urandom_range(0, 131072))) - 32'sd65536;
            2: return ($urandom_range(0, 1)) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed(32'($urandom_range(0, 16777216))) - 32'sd8388608;
        endcase
    endfunction

    function automatic logic [16:0] rand_weight();
        case ($urandom_range(0, 7))
            0: return 17'($urandom_range(65537, 131071));
            1: return lbs_pkg::ONE_Q16;
            2: return 17'($urandom_range(0, 15));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    t_row directed [$];
    int   ready_bones [$];
    int   n_inf;
    t_row r;

    task automatic add_row(input t_row row);
        directed.insert(directed.size(), row);
    endtask

    initial begin
        // bone 0: identity with extreme translation terms
        for (int e = 0; e < lbs_pkg::ELEMS; e++)
            add_row(load_row(6'd0, 4'(e),
                (e == 0 || e == 5 || e == 10) ? 32'sd65536 :
                (e == 3) ? 32'sh7fffffff : (e == 7) ? 32'sh80000000 : 32'sd0));
        r = load_row(6'd0, 4'd15, 32'sh12345678);
        r.last = 1'b1;
        add_row(r);
        r = inf_row(6'd0, 17'd0, 1'b1, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
        r.typed = 1'b1;
        add_row(r);
        add_row(inf_row(6'd0, lbs_pkg::ONE_Q16, 1'b0, 0, 0, 0));
        r = inf_row(6'd0, 17'h1ffff, 1'b1, 0, 0, 0);
        r.typed = 1'b1;
        r.res = '{32'sh7fffffff, 32'sh80000000, 32'sd0};
        add_row(r);
        add_row(inf_row(6'd0, lbs_pkg::ONE_Q16, 1'b1, 32'sh7fffffff,
                        32'sh80000000, 32'sh7fffffff));
        add_row(inf_row(6'd0, 17'd1, 1'b1, -32'sd1, -32'sd1, -32'sd1));

        foreach (blend[c]) blend[c] = 0;
        inf_count = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) send(directed[i]);

        while (n_items < RANDOM_ITEMS + directed.size()) begin
            ready_bones.delete();
            for (int b = 0; b < lbs_pkg::BONES; b++) begin
                bit ok;
                ok = 1'b1;
                for (int e = 0; e < lbs_pkg::ELEMS; e++)
                    ok &= written[b*lbs_pkg::ELEMS + e];
                if (ok) ready_bones.insert(ready_bones.size(), b);
            end
            if (ready_bones.size() < 2 || $urandom_range(0, 4) == 0) begin
                if ($urandom_range(0, 1)) begin
                    int b;
                    b = $urandom_range(0, lbs_pkg::BONES - 1);
                    for (int e = 0; e < lbs_pkg::ELEMS; e++)
                        send(load_row(6'(b), 4'(e), rand_value()));
                end else begin
                    send(load_row(6'($urandom), 4'($urandom), rand_value()));
                end
            end else begin
                case ($urandom_range(0, 9))
                    0:       n_inf = $urandom_range(11, 13);
                    1, 2:    n_inf = $urandom_range(5, 10);
                    default: n_inf = $urandom_range(1, 4);
                endcase
                for (int k = 0; k < n_inf; k++)
                    send(inf_row(6'(ready_bones[$urandom_range(0, ready_bones.size()-1)]),
                                 rand_weight(), k == n_inf - 1, rand_value(),
                                 rand_value(), rand_value()));
            end
        end
        s_valid <= 1'b0;

        while (skinned_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("%0d transfers in (%0d palette loads), %0d vertices skinned, %0d checked",
                 n_items, n_writes, n_vertices, n_results);
        if (errors == 0 && skinned_q.size() == 0) begin
            $display("linear_blend_skinning_tb passed");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, skinned_q.size());
            $display("linear_blend_skinning_tb failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
